// ===== rtl/brb_pkg.sv =====
package brb_pkg;

    localparam int DEPTH_DEF = 4096;
    localparam int FIELD_W   = 13;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 3;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH      = 3'd0,
        REQ_POP       = 3'd1,
        REQ_PEEK      = 3'd2,
        REQ_COMMIT_WR = 3'd3,
        REQ_COMMIT_RD = 3'd4,
        REQ_CLEAR     = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } t_err;

    typedef struct packed {
        logic vld;
        logic rd;
        t_err err;
    } t_pend;

endpackage

// ===== rtl/brb_ram.sv =====
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/brb_ctrl.sv =====
module brb_ctrl import brb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [REQ_W-1:0]   i_req,
    input  logic [BYTE_W-1:0]  i_data,
    input  logic [FIELD_W-1:0] i_amount,
    input  logic               i_adv,
    output t_pend              o_pend,
    output logic [AW-1:0]      o_head,
    output logic [AW-1:0]      o_tail,
    output logic [CW-1:0]      o_count,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [BYTE_W-1:0]  o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr
);

    localparam int SW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(idx) + (CW+1)'(n);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    t_pend         r_pend, n_pend;
    logic          acc;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_err          err;
    logic [SW-1:0] cnt_w;
    logic [SW-1:0] amt_w;
    logic [CW-1:0] amt_n;

    assign o_ready = !r_pend.vld;
    assign acc     = i_valid && o_ready;
    assign cnt_w   = SW'(r_count);
    assign amt_w   = SW'(i_amount);
    assign amt_n   = CW'(i_amount);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_head;
        err     = ERR_OK;
        case (i_req)
            REQ_PUSH: begin
                if (r_count == DEPTH_C) begin
                    err = ERR_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_tail  = ring_add(r_tail, CW'(1));
                    n_count = r_count + CW'(1);
                end
            end
            REQ_POP: begin
                if (r_count == '0) begin
                    err = ERR_UNDERFLOW;
                end else begin
                    rd_en   = 1'b1;
                    n_head  = ring_add(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            REQ_PEEK: begin
                if (amt_w >= cnt_w) begin
                    err = ERR_UNDERFLOW;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ring_add(r_head, amt_n);
                end
            end
            REQ_COMMIT_WR: begin
                if (amt_w == '0) begin
                    err = ERR_UNDERFLOW;
                end else if (cnt_w + amt_w > SW'(DEPTH)) begin
                    err = ERR_OVERFLOW;
                end else begin
                    n_tail  = ring_add(r_tail, amt_n);
                    n_count = CW'(cnt_w + amt_w);
                end
            end
            REQ_COMMIT_RD: begin
                if (amt_w == '0 || amt_w > cnt_w) begin
                    err = ERR_UNDERFLOW;
                end else begin
                    n_head  = ring_add(r_head, amt_n);
                    n_count = CW'(cnt_w - amt_w);
                end
            end
            REQ_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (i_adv) begin
            n_pend.vld = 1'b0;
        end
        if (acc) begin
            n_pend.vld = 1'b1;
            n_pend.rd  = rd_en;
            n_pend.err = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pend  <= '0;
        end else begin
            r_pend <= n_pend;
            if (acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    assign o_pend    = r_pend;
    assign o_head    = r_head;
    assign o_tail    = r_tail;
    assign o_count   = r_count;
    assign o_wr_en   = acc && wr_en;
    assign o_wr_addr = r_tail;
    assign o_wr_data = i_data;
    assign o_rd_en   = acc && rd_en;
    assign o_rd_addr = rd_addr;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count exceeds the capacity");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == ring_add(r_head, r_count))
        else $error("tail does not follow head by the fill count");

    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && err != ERR_OK) |=>
            (r_count == $past(r_count) && r_head == $past(r_head)
             && r_tail == $past(r_tail)))
        else $error("failed request changed the pointers");

    a_accept_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_pend.vld && r_pend.err == $past(err)))
        else $error("accepted request left no pending result");
`endif

endmodule

// ===== rtl/brb_report.sv =====
module brb_report import brb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pend                 i_pend,
    input  logic [BYTE_W-1:0]     i_rd_data,
    input  logic [AW-1:0]         i_head,
    input  logic [AW-1:0]         i_tail,
    input  logic [CW-1:0]         i_count,
    output logic                  o_adv,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic               r_out_vld, n_out_vld;
    logic [BYTE_W-1:0]  r_data;
    logic [FIELD_W-1:0] r_fill;
    logic [FIELD_W-1:0] r_rs1;
    logic [FIELD_W-1:0] r_rs2;
    logic [FIELD_W-1:0] r_ws1;
    logic [FIELD_W-1:0] r_ws2;
    t_err               r_err;
    logic [CW-1:0]      to_end;
    logic [CW-1:0]      rs1;
    logic [CW-1:0]      rs2;
    logic [CW-1:0]      ws1;
    logic [CW-1:0]      ws2;

    assign o_adv = i_pend.vld && (!r_out_vld || i_ready);

    always_comb begin
        to_end = DEPTH_C - CW'(i_head);
        rs1    = '0;
        rs2    = '0;
        ws1    = '0;
        ws2    = '0;
        if (i_count != '0) begin
            if (i_count <= to_end) begin
                rs1 = i_count;
            end else begin
                rs1 = to_end;
                rs2 = i_count - to_end;
            end
        end
        if (i_count < DEPTH_C) begin
            if (i_tail >= i_head) begin
                ws1 = DEPTH_C - CW'(i_tail);
                ws2 = CW'(i_head);
            end else begin
                ws1 = CW'(i_head) - CW'(i_tail);
            end
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (i_ready) begin
            n_out_vld = 1'b0;
        end
        if (o_adv) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_data <= i_pend.rd ? i_rd_data : '0;
            r_fill <= FIELD_W'(i_count);
            r_rs1  <= FIELD_W'(rs1);
            r_rs2  <= FIELD_W'(rs2);
            r_ws1  <= FIELD_W'(ws1);
            r_ws2  <= FIELD_W'(ws2);
            r_err  <= i_pend.err;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = {5'd0, r_err, r_ws2, r_ws1, r_rs2, r_rs1, r_fill, r_data};

`ifndef SYNTHESIS
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_err != ERR_OK) |-> r_data == '0)
        else $error("failed request returned a nonzero byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |-> !o_adv)
        else $error("waiting result overwritten");

    a_span_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv |-> (CW+1)'(rs1) + (CW+1)'(rs2) == (CW+1)'(i_count))
        else $error("read spans do not add up to the fill count");
`endif

endmodule

// ===== rtl/byte_ring_buffer.sv =====
// Circular byte store of DEPTH entries with head, tail and fill count. Each
// request on the slave side pushes, pops, peeks at an offset from the head,
// commits a length written or consumed, or clears the pointers, and gives
// exactly one result on the master side carrying the byte read, the fill count,
// the two readable and two writable span lengths after the request, and an
// error code. A request that would overflow or underflow changes nothing. The
// byte RAM registers its read data, and the result of a request is then
// registered in the output register once that register is free. A new request
// is taken only after the result of the last one has moved into the output
// register. The output register lets the next request in while a result is
// still waiting. Bytes never pushed read as anything, and no clearing pass
// runs after reset.
module byte_ring_buffer import brb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_in [7:0], amount [20:8], zero [23:21]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [2:0]
    input  logic [REQ_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // data_out [7:0], fill_count [20:8], read_span_first [33:21],
    // read_span_second [46:34], write_span_first [59:47],
    // write_span_second [72:60], error_code [74:73], zero [79:75]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_pend             pend;
    logic              adv;
    logic [AW-1:0]     head;
    logic [AW-1:0]     tail;
    logic [CW-1:0]     count;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    brb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_req     (s_axis_tuser),
        .i_data    (s_axis_tdata[7:0]),
        .i_amount  (s_axis_tdata[20:8]),
        .i_adv     (adv),
        .o_pend    (pend),
        .o_head    (head),
        .o_tail    (tail),
        .o_count   (count),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    brb_report #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_report (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pend    (pend),
        .i_rd_data (rd_data),
        .i_head    (head),
        .i_tail    (tail),
        .i_count   (count),
        .o_adv     (adv),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule
